// File: src/wphv_pkg.sv
`default_nettype none
package wphv_pkg;

    localparam int TRIG_TABLE_BITS = 10;
    localparam int TANH_TABLE_BITS = 10;

    localparam logic [1:0] REG_CAPTURE = 2'd0;
    localparam logic [1:0] REG_GAIN_SURGE = 2'd1;
    localparam logic [1:0] REG_GAIN_SWAY = 2'd2;
    localparam logic [1:0] REG_GAIN_YAW = 2'd3;

    typedef struct packed {
        logic [31:0] capture_distance;
        logic signed [15:0] gain_surge;
        logic signed [15:0] gain_sway;
        logic signed [15:0] gain_yaw;
    } t_cfg;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    function automatic logic [63:0] sin_quarter(input logic [14:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        x = ({49'd0, r} * HALF_PI_Q30) >> 14;
        x2 = (x * x) >> 30;
        s = Q30_ONE - x2 / 64'd110;
        s = Q30_ONE - ((x2 * s) >> 30) / 64'd72;
        s = Q30_ONE - ((x2 * s) >> 30) / 64'd42;
        s = Q30_ONE - ((x2 * s) >> 30) / 64'd20;
        s = Q30_ONE - ((x2 * s) >> 30) / 64'd6;
        return (x * s) >> 30;
    endfunction

    // sin of a binary angle, Q16 (range -65536..65536)
    function automatic logic signed [17:0] sin_q16(input logic [15:0] a);
        logic [1:0] q;
        logic [14:0] r;
        logic [63:0] v;
        logic signed [17:0] sv;
        q = a[15:14];
        r = {1'b0, a[13:0]};
        v = ((q[0] ? sin_quarter(15'd16384 - r) : sin_quarter(r)) + 64'd8192) >> 14;
        sv = $signed(v[17:0]);
        return q[1] ? -sv : sv;
    endfunction

    function automatic logic [63:0] exp_neg_small(input logic [63:0] z);
        logic [63:0] r;
        r = Q30_ONE;
        r = Q30_ONE - ((z * r) >> 30) / 64'd12;
        r = Q30_ONE - ((z * r) >> 30) / 64'd11;
        r = Q30_ONE - ((z * r) >> 30) / 64'd10;
        r = Q30_ONE - ((z * r) >> 30) / 64'd9;
        r = Q30_ONE - ((z * r) >> 30) / 64'd8;
        r = Q30_ONE - ((z * r) >> 30) / 64'd7;
        r = Q30_ONE - ((z * r) >> 30) / 64'd6;
        r = Q30_ONE - ((z * r) >> 30) / 64'd5;
        r = Q30_ONE - ((z * r) >> 30) / 64'd4;
        r = Q30_ONE - ((z * r) >> 30) / 64'd3;
        r = Q30_ONE - ((z * r) >> 30) / 64'd2;
        r = Q30_ONE - ((z * r) >> 30);
        return r;
    endfunction

    // e^(-2x) for tanh table entry i, Q30
    function automatic logic [63:0] tanh_exp(input logic [63:0] i);
        logic [63:0] t;
        t = exp_neg_small(i << (30 - TANH_TABLE_BITS));
        for (int k = 0; k < 4; k++) begin
            t = (t * t + (64'd1 << 29)) >> 30;
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// File: src/wphv_cfg.sv
`default_nettype none
module wphv_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output wphv_pkg::t_cfg   o_cfg
);
    wphv_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capture_distance <= 32'd65536;
            r_cfg.gain_surge <= 16'sd256;
            r_cfg.gain_sway <= 16'sd256;
            r_cfg.gain_yaw <= 16'sd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wphv_pkg::REG_CAPTURE: r_cfg.capture_distance <= i_cfg_data;
                wphv_pkg::REG_GAIN_SURGE: r_cfg.gain_surge <= i_cfg_data[15:0];
                wphv_pkg::REG_GAIN_SWAY: r_cfg.gain_sway <= i_cfg_data[15:0];
                wphv_pkg::REG_GAIN_YAW: r_cfg.gain_yaw <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: src/wphv_core.sv
`default_nettype none
module wphv_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire logic [159:0] i_data,
    input  wphv_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    output logic [56:0]       o_data
);
    localparam int TS = 16 - wphv_pkg::TRIG_TABLE_BITS;
    localparam int TN = 1 << wphv_pkg::TRIG_TABLE_BITS;
    localparam int HN = 1 << wphv_pkg::TANH_TABLE_BITS;
    localparam int HS = 19 - wphv_pkg::TANH_TABLE_BITS;

    logic [3:0] r_v;

    // sin table over a full turn, cos read a quarter turn ahead
    logic signed [17:0] w_sin_tab [TN];
    for (genvar g = 0; g < TN; g++) begin : g_sin
        localparam logic signed [17:0] SIN_VAL = wphv_pkg::sin_q16(16'(g << TS));
        assign w_sin_tab[g] = SIN_VAL;
    end

    // tanh magnitude table over [0, 8)
    logic [16:0] w_tanh_tab [HN];
    for (genvar g = 0; g < HN; g++) begin : g_tanh
        localparam logic [63:0] EXP_SQ = wphv_pkg::tanh_exp(64'(g));
        localparam logic [63:0] NUM = (wphv_pkg::Q30_ONE - EXP_SQ) << 16;
        localparam logic [63:0] DEN = wphv_pkg::Q30_ONE + EXP_SQ;
        localparam logic [63:0] TANH_VAL = (NUM + (DEN >> 1)) / DEN;
        assign w_tanh_tab[g] = TANH_VAL[16:0];
    end

    // stage 1: errors, trig lookup, heading error
    logic signed [32:0] r1_ex, r1_ey;
    logic signed [17:0] r1_s, r1_c;
    logic signed [15:0] r1_e;
    logic [wphv_pkg::TRIG_TABLE_BITS-1:0] w_ai;
    logic [wphv_pkg::TRIG_TABLE_BITS-1:0] w_ci;
    assign w_ai = i_data[79:80-wphv_pkg::TRIG_TABLE_BITS];
    assign w_ci = w_ai + {2'b01, {(wphv_pkg::TRIG_TABLE_BITS-2){1'b0}}};

    // stage 2: products
    logic [65:0] r2_sx, r2_sy;
    logic signed [51:0] r2_cx, r2_sy2, r2_sx2, r2_cy;
    logic signed [39:0] r2_yaw;
    // stage 3: sums, compare, tanh
    logic r3_far;
    logic [16:0] r3_xm, r3_ym;
    logic r3_xo, r3_yo;
    logic r3_xn, r3_yn;
    logic signed [39:0] r3_yaw;
    // stage 4: gains, saturation
    logic signed [15:0] r4_su, r4_sw;
    logic signed [23:0] r4_yr;
    logic r4_re;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[2:0], i_valid};
    end

    logic [32:0] w_mx, w_my;
    logic [66:0] w_sum;
    logic [63:0] w_cd2;
    logic signed [52:0] w_bx, w_by;
    logic signed [36:0] w_bxs, w_bys;
    logic [36:0] w_mbx, w_mby;
    logic [36:0] w_xidx, w_yidx;
    logic signed [17:0] w_tx, w_ty;
    logic signed [34:0] w_px, w_py;
    logic signed [34:0] w_ps, w_pw;
    logic signed [47:0] w_ye;

    assign w_mx = r1_ex[32] ? 33'(-r1_ex) : 33'(r1_ex);
    assign w_my = r1_ey[32] ? 33'(-r1_ey) : 33'(r1_ey);
    assign w_sum = {1'b0, r2_sx} + {1'b0, r2_sy};
    assign w_cd2 = {32'd0, i_cfg.capture_distance} * {32'd0, i_cfg.capture_distance};
    assign w_bx = 53'(r2_cx) - 53'(r2_sy2);
    assign w_by = 53'(r2_sx2) + 53'(r2_cy);
    assign w_bxs = 37'(w_bx >>> 16);
    assign w_bys = 37'(w_by >>> 16);
    assign w_mbx = w_bxs[36] ? 37'(-w_bxs) : 37'(w_bxs);
    assign w_mby = w_bys[36] ? 37'(-w_bys) : 37'(w_bys);
    assign w_xidx = w_mbx >> HS;
    assign w_yidx = w_mby >> HS;

    // negative tanh folds into the sign of the gain product
    assign w_tx = r3_xo ? 18'sd65536 : $signed({1'b0, r3_xm});
    assign w_ty = r3_yo ? 18'sd65536 : $signed({1'b0, r3_ym});
    assign w_px = 35'(w_tx) * 35'(i_cfg.gain_surge);
    assign w_py = 35'(w_ty) * 35'(i_cfg.gain_sway);
    assign w_ps = (r3_xn ? w_px : -w_px) >>> 16;
    assign w_pw = (r3_yn ? w_py : -w_py) >>> 16;
    assign w_ye = 48'(-r3_yaw) >>> 15;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ex <= 33'($signed(i_data[31:0])) - 33'($signed(i_data[111:80]));
            r1_ey <= 33'($signed(i_data[63:32])) - 33'($signed(i_data[143:112]));
            r1_s <= w_sin_tab[w_ai];
            r1_c <= w_sin_tab[w_ci];
            r1_e <= $signed(i_data[79:64] - i_data[159:144]);

            r2_sx <= {33'd0, w_mx} * {33'd0, w_mx};
            r2_sy <= {33'd0, w_my} * {33'd0, w_my};
            r2_cx <= r1_c * r1_ex;
            r2_sy2 <= r1_s * r1_ey;
            r2_sx2 <= r1_s * r1_ex;
            r2_cy <= r1_c * r1_ey;
            r2_yaw <= 40'(r1_e) * 40'(i_cfg.gain_yaw) * 40'sd180;

            r3_far <= w_sum > {3'd0, w_cd2};
            r3_xm <= w_tanh_tab[w_xidx[wphv_pkg::TANH_TABLE_BITS-1:0]];
            r3_ym <= w_tanh_tab[w_yidx[wphv_pkg::TANH_TABLE_BITS-1:0]];
            r3_xo <= w_xidx >= 37'(HN);
            r3_yo <= w_yidx >= 37'(HN);
            r3_xn <= w_bxs[36];
            r3_yn <= w_bys[36];
            r3_yaw <= r2_yaw;

            r4_re <= !r3_far;
            r4_su <= !r3_far ? 16'sd0 : (w_ps > 35'sd32767 ? 16'sd32767 :
                     (w_ps < -35'sd32768 ? -16'sd32768 : 16'(w_ps)));
            r4_sw <= !r3_far ? 16'sd0 : (w_pw > 35'sd32767 ? 16'sd32767 :
                     (w_pw < -35'sd32768 ? -16'sd32768 : 16'(w_pw)));
            r4_yr <= w_ye > 48'sd8388607 ? 24'sd8388607 :
                     (w_ye < -48'sd8388608 ? -24'sd8388608 : 24'(w_ye));
        end
    end

    assign o_valid = r_v[3];
    assign o_data = {r4_re, r4_yr, r4_sw, r4_su};
endmodule
`default_nettype wire

// File: src/waypoint_heading_velocity_ref.sv
`default_nettype none
// Waypoint velocity reference: one item per clock through a four-stage pipeline
// (errors and trig tables, products, distance compare and tanh table, gain
// scaling and saturation); the whole pipeline holds when the output is stalled.
// The user must write configuration through the cfg channel while idle (unenforced).
module waypoint_heading_velocity_ref (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x, pos_y, heading, target_x, target_y, target_heading
    input  wire logic [159:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // surge_ref, sway_ref, yaw_rate_ref, reached
    output logic [63:0]       m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    wphv_pkg::t_cfg w_cfg;
    logic w_en;
    logic [56:0] w_data;

    assign w_en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = w_en;
    assign m_axis_tdata = {7'd0, w_data};

    wphv_cfg u_cfg (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_cfg(w_cfg)
    );

    wphv_core u_core (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(s_axis_tvalid && w_en),
        .i_data(s_axis_tdata), .i_cfg(w_cfg), .o_valid(m_axis_tvalid), .o_data(w_data)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[56] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("reached with nonzero velocity");
endmodule
`default_nettype wire
